// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst, a, c)
`define ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

// ----- rtl/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg
// Types, constants and CORDIC helpers of the sphere texture lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package stl_pkg;

  localparam int TEX_DEPTH = 65536;
  localparam int TEX_AW    = $clog2(TEX_DEPTH);
  localparam int MAX_SIDE  = 256;
  localparam int SIDE_W    = $clog2(MAX_SIDE) + 1;
  localparam int ROW_W     = $clog2(MAX_SIDE);
  localparam int PROD_W    = 32 + SIDE_W;
  localparam int RAW_W     = 33;
  localparam int NORM_MSB  = 40;
  localparam int DW        = NORM_MSB + 2;
  localparam int CW        = 46;
  localparam int SH_W      = $clog2(NORM_MSB + 1);
  localparam int STEPS     = 30;
  localparam int STEP_W    = $clog2(STEPS);
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  localparam logic [20:0] GAIN_Q20     = 21'd1726753;
  localparam logic [15:0] RECIP_255    = 16'd32897;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
  localparam logic [31:0] REFLEX_LIMIT = 32'hC000_0000;

  localparam logic [31:0] ARC_TABLE [STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_FORWARD_X  = 3'd1;
  localparam logic [2:0] REG_FORWARD_Y  = 3'd2;
  localparam logic [2:0] REG_FORWARD_Z  = 3'd3;
  localparam logic [2:0] REG_COLUMNS    = 3'd4;
  localparam logic [2:0] REG_ROWS       = 3'd5;

  typedef enum logic [2:0] {
    CLS_LOAD,
    CLS_ZERO,
    CLS_UP,
    CLS_DOWN,
    CLS_NORMAL
  } item_class_t;

  typedef struct packed {
    logic               operation;
    logic [15:0]        texel_address;
    logic [7:0]         texel_red;
    logic [7:0]         texel_green;
    logic [7:0]         texel_blue;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ambient_red;
    logic [15:0] ambient_green;
    logic [15:0] ambient_blue;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        brightness;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_z;
    logic [SIDE_W-1:0]  cols;
    logic [SIDE_W-1:0]  rows;
  } cfg_t;

  typedef struct packed {
    item_class_t        cls;
    logic [TEX_AW-1:0]  addr;
    logic [23:0]        rgb;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic signed [DW-1:0] fx;
    logic signed [DW-1:0] fz;
    logic               fzero;
  } qword_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [31:0]          ang;
  } cordic_t;

  // Half-turn pre-rotation so that x starts non-negative.
  function automatic cordic_t cordic_pre(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    cordic_t r;
    if (x < 0) begin
      r.x = -x;
      r.y = -y;
      r.ang = HALF_TURN;
    end else begin
      r.x = x;
      r.y = y;
      r.ang = '0;
    end
    return r;
  endfunction

  // One vectoring step with floor shifts.
  function automatic cordic_t cordic_iter(cordic_t c, int unsigned i);
    cordic_t r;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    sx = c.y >>> i;
    sy = c.x >>> i;
    if (c.y > 0) begin
      r.x = c.x + sx;
      r.y = c.y - sy;
      r.ang = c.ang + ARC_TABLE[i[STEP_W-1:0]];
    end else begin
      r.x = c.x - sx;
      r.y = c.y + sy;
      r.ang = c.ang - ARC_TABLE[i[STEP_W-1:0]];
    end
    return r;
  endfunction

  function automatic logic [2:0] msb8(logic [7:0] b);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] side_size(logic [SIDE_W-1:0] r);
    logic [SIDE_W-1:0] s;
    if (r == '0) s = SIDE_W'(1);
    else if (r > SIDE_W'(MAX_SIDE)) s = SIDE_W'(MAX_SIDE);
    else s = r;
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/stl_front.sv -----
// ----------------------------------------------------------------------------
// stl_front
// Accepts words, forms the offset, normalizes it and classifies the item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stl_front (
  input  logic              clk,
  input  logic              rst,
  input  stl_pkg::cfg_t     cfg,
  input  logic              push,
  output logic              full,
  input  stl_pkg::in_item_t item,
  input  logic              q_full,
  output logic              q_push,
  output stl_pkg::qword_t   q_word
);
  import stl_pkg::*;

  localparam int FW     = 17;
  localparam int ND_GRP = (RAW_W + 7) / 8;
  localparam int NF_GRP = (FW + 7) / 8;

  typedef struct packed {
    logic                    op;
    logic [TEX_AW-1:0]       addr;
    logic [23:0]             rgb;
    logic signed [RAW_W-1:0] dx;
    logic signed [RAW_W-1:0] dy;
    logic signed [RAW_W-1:0] dz;
    logic signed [15:0]      fx;
    logic signed [15:0]      fz;
  } front_item_t;

  logic adv;
  logic v0, v1, v2, v3, v4;
  in_item_t    it0;
  front_item_t fr1, fr2, fr3;
  logic [RAW_W-1:0] or_d1;
  logic [FW-1:0]    or_f1;
  logic [2:0] gm_d2 [ND_GRP];
  logic       gnz_d2 [ND_GRP];
  logic [2:0] gm_f2 [NF_GRP];
  logic       gnz_f2 [NF_GRP];
  logic [SH_W-1:0] sd3, sf3;
  logic            zd3, zf3;

  assign adv    = !v4 || !q_full;
  assign full   = !adv;
  assign q_push = v4 && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v0 <= push;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Offset and magnitude bound.
  logic signed [RAW_W-1:0] dx, dy, dz;
  logic [RAW_W-1:0] ax, ay, az;
  logic signed [FW-1:0] fxw, fzw;
  logic [FW-1:0] afx, afz;
  always_comb begin
    dx  = RAW_W'(it0.hit_x) - RAW_W'(it0.centre_x);
    dy  = RAW_W'(it0.hit_y) - RAW_W'(it0.centre_y);
    dz  = RAW_W'(it0.hit_z) - RAW_W'(it0.centre_z);
    ax  = dx[RAW_W-1] ? RAW_W'(-dx) : RAW_W'(dx);
    ay  = dy[RAW_W-1] ? RAW_W'(-dy) : RAW_W'(dy);
    az  = dz[RAW_W-1] ? RAW_W'(-dz) : RAW_W'(dz);
    fxw = FW'(cfg.fwd_x);
    fzw = FW'(cfg.fwd_z);
    afx = fxw[FW-1] ? FW'(-fxw) : FW'(fxw);
    afz = fzw[FW-1] ? FW'(-fzw) : FW'(fzw);
  end

  // Leading one per byte, then across bytes.
  logic [ND_GRP*8-1:0] pad_d;
  logic [NF_GRP*8-1:0] pad_f;
  assign pad_d = (ND_GRP*8)'(or_d1);
  assign pad_f = (NF_GRP*8)'(or_f1);

  logic [SH_W-1:0] pm_d, pm_f;
  logic            nz_d, nz_f;
  always_comb begin
    pm_d = '0;
    nz_d = 1'b0;
    for (int g = 0; g < ND_GRP; g++) begin
      if (gnz_d2[g]) begin
        pm_d = SH_W'(g * 8) + SH_W'(gm_d2[g]);
        nz_d = 1'b1;
      end
    end
    pm_f = '0;
    nz_f = 1'b0;
    for (int g = 0; g < NF_GRP; g++) begin
      if (gnz_f2[g]) begin
        pm_f = SH_W'(g * 8) + SH_W'(gm_f2[g]);
        nz_f = 1'b1;
      end
    end
  end

  item_class_t cls4;
  always_comb begin
    if (fr3.op == OP_LOAD) cls4 = CLS_LOAD;
    else if (zd3) cls4 = CLS_ZERO;
    else if (fr3.dx == '0 && fr3.dz == '0) cls4 = (fr3.dy > 0) ? CLS_UP : CLS_DOWN;
    else cls4 = CLS_NORMAL;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it0 <= item;

      fr1.op   <= it0.operation;
      fr1.addr <= it0.texel_address;
      fr1.rgb  <= {it0.texel_red, it0.texel_green, it0.texel_blue};
      fr1.dx   <= dx;
      fr1.dy   <= dy;
      fr1.dz   <= dz;
      fr1.fx   <= cfg.fwd_x;
      fr1.fz   <= cfg.fwd_z;
      or_d1    <= ax | ay | az;
      or_f1    <= afx | afz;

      fr2 <= fr1;
      for (int g = 0; g < ND_GRP; g++) begin
        gm_d2[g]  <= msb8(pad_d[g*8 +: 8]);
        gnz_d2[g] <= |pad_d[g*8 +: 8];
      end
      for (int g = 0; g < NF_GRP; g++) begin
        gm_f2[g]  <= msb8(pad_f[g*8 +: 8]);
        gnz_f2[g] <= |pad_f[g*8 +: 8];
      end

      fr3 <= fr2;
      sd3 <= SH_W'(NORM_MSB) - pm_d;
      sf3 <= SH_W'(NORM_MSB) - pm_f;
      zd3 <= !nz_d;
      zf3 <= !nz_f;

      q_word.cls   <= cls4;
      q_word.addr  <= fr3.addr;
      q_word.rgb   <= fr3.rgb;
      q_word.dx    <= DW'(fr3.dx) <<< sd3;
      q_word.dy    <= DW'(fr3.dy) <<< sd3;
      q_word.dz    <= DW'(fr3.dz) <<< sd3;
      q_word.fx    <= DW'(fr3.fx) <<< sf3;
      q_word.fz    <= DW'(fr3.fz) <<< sf3;
      q_word.fzero <= zf3;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/stl_queue.sv -----
// ----------------------------------------------------------------------------
// stl_queue
// Short show-ahead queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  stl_pkg::qword_t  wdata,
  input  logic             pop,
  output stl_pkg::qword_t  rdata,
  output stl_pkg::q_stat_t stat
);
  import stl_pkg::*;

  qword_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_AW:0]   count;

  assign stat.full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

endmodule
`default_nettype wire

// ----- rtl/stl_back.sv -----
// ----------------------------------------------------------------------------
// stl_back
// CORDIC angle lanes, texel addressing, texture memory and color scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stl_back (
  input  logic               clk,
  input  logic               rst,
  input  stl_pkg::cfg_t      cfg,
  input  stl_pkg::qword_t    q_word,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output stl_pkg::out_item_t result
);
  import stl_pkg::*;

  typedef struct packed {
    item_class_t       cls;
    logic [TEX_AW-1:0] addr;
    logic [23:0]       rgb;
    logic              fzero;
  } meta_t;

  logic adv;
  logic res_v;

  assign adv   = !res_v || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !res_v;

  logic [SIDE_W-1:0] rows, cols;
  assign rows = side_size(cfg.rows);
  assign cols = side_size(cfg.cols);

  // Azimuth lanes: offset (x,z) and forward (x,z), plus the scaled y term.
  logic    va [0:STEPS];
  cordic_t ca [0:STEPS];
  cordic_t cf [0:STEPS];
  meta_t   ma [0:STEPS];
  logic signed [CW-1:0] pa [1:STEPS];
  logic signed [42:0]   php;
  logic [41:0]          plp;

  always_ff @(posedge clk) begin
    if (rst) va[0] <= 1'b0;
    else if (adv) va[0] <= !q_empty;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ca[0] <= cordic_pre(CW'(q_word.dx), CW'(q_word.dz));
      cf[0] <= cordic_pre(CW'(q_word.fx), CW'(q_word.fz));
      ma[0] <= '{cls: q_word.cls, addr: q_word.addr, rgb: q_word.rgb,
                 fzero: q_word.fzero};
      // The gain product is split at bit 21 into two narrow multiplies.
      php <= $signed(q_word.dy[DW-1:21]) * $signed({1'b0, GAIN_Q20});
      plp <= q_word.dy[20:0] * GAIN_Q20;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) pa[1] <= (CW'(php) <<< 1) + $signed(CW'(plp >> 20));
  end

  for (genvar k = 2; k <= STEPS; k++) begin : g_pdly
    always_ff @(posedge clk) begin
      if (adv) pa[k] <= pa[k-1];
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_az
    always_ff @(posedge clk) begin
      if (rst) va[k] <= 1'b0;
      else if (adv) va[k] <= va[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ca[k] <= cordic_iter(ca[k-1], k - 1);
        cf[k] <= cordic_iter(cf[k-1], k - 1);
        ma[k] <= ma[k-1];
      end
    end
  end

  // Polar lane on (scaled y, horizontal length).
  logic        vp  [0:STEPS];
  cordic_t     cp  [0:STEPS];
  meta_t       mp  [0:STEPS];
  logic [31:0] azc [0:STEPS];
  logic [31:0] azf [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) vp[0] <= 1'b0;
    else if (adv) vp[0] <= va[STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cp[0]  <= cordic_pre(pa[STEPS], ca[STEPS].x);
      mp[0]  <= ma[STEPS];
      azc[0] <= ca[STEPS].ang;
      azf[0] <= ma[STEPS].fzero ? QUARTER_TURN : cf[STEPS].ang;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_pol
    always_ff @(posedge clk) begin
      if (rst) vp[k] <= 1'b0;
      else if (adv) vp[k] <= vp[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cp[k]  <= cordic_iter(cp[k-1], k - 1);
        mp[k]  <= mp[k-1];
        azc[k] <= azc[k-1];
        azf[k] <= azf[k-1];
      end
    end
  end

  // Row and column scaling.
  logic [31:0]       th, th_c, tv;
  logic [PROD_W-1:0] rprod, cprod;
  logic              tz0, vr0;
  meta_t             m0;

  always_comb begin
    th = cp[STEPS].ang;
    if (th >= REFLEX_LIMIT) th_c = '0;
    else if (th > HALF_TURN) th_c = HALF_TURN;
    else th_c = th;
    tv = azf[STEPS] + EIGHTH_TURN - azc[STEPS];
  end

  logic [SIDE_W:0]   rr;
  logic [SIDE_W-1:0] cr;
  logic [ROW_W-1:0]  row_n, col_n;
  always_comb begin
    rr = rprod[PROD_W-1:31];
    cr = cprod[PROD_W-1:32];
    row_n = (rr >= (SIDE_W+1)'(rows)) ? ROW_W'(rows - 1'b1) : ROW_W'(rr);
    col_n = (tz0 || cr >= cols) ? ROW_W'(cols - 1'b1) : ROW_W'(cr);
    case (m0.cls) inside
      CLS_ZERO, CLS_UP: begin
        row_n = '0;
        col_n = '0;
      end
      CLS_DOWN: begin
        row_n = ROW_W'(rows - 1'b1);
        col_n = '0;
      end
      default: ;
    endcase
  end

  logic              vr1, vr2, vm, vs0, vs1;
  meta_t             m1, m2;
  logic [ROW_W-1:0]  row1, col1;
  logic [TEX_AW-1:0] addr2;
  logic [ROW_W+SIDE_W-1:0] lin;
  assign lin = row1 * cols + (ROW_W+SIDE_W)'(col1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vr0   <= 1'b0;
      vr1   <= 1'b0;
      vr2   <= 1'b0;
      vm    <= 1'b0;
      vs0   <= 1'b0;
      vs1   <= 1'b0;
      res_v <= 1'b0;
    end else if (adv) begin
      vr0   <= vp[STEPS];
      vr1   <= vr0;
      vr2   <= vr1;
      vm    <= vr2 && (m2.cls != CLS_LOAD);
      vs0   <= vm;
      vs1   <= vs0;
      res_v <= vs1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rprod <= th_c * rows;
      cprod <= tv * cols;
      tz0   <= (tv == '0);
      m0    <= mp[STEPS];
      row1  <= row_n;
      col1  <= col_n;
      m1    <= m0;
      m2    <= m1;
      addr2 <= (m1.cls == CLS_LOAD) ? m1.addr : TEX_AW'(lin);
    end
  end

  // Texture store; loads write here in item order.
  logic [23:0] tex_mem [TEX_DEPTH];
  logic [23:0] tex_rd;

  always_ff @(posedge clk) begin
    if (adv && vr2 && m2.cls == CLS_LOAD) tex_mem[addr2] <= m2.rgb;
    if (adv) tex_rd <= tex_mem[addr2];
  end

  // Brightness scaling and exact division by 255.
  logic [23:0] bp0 [3];
  logic [23:0] bp1 [3];
  logic [16:0] qe1 [3];
  logic [39:0] rp  [3];
  logic [24:0] chk [3];
  logic [16:0] qf  [3];
  logic [15:0] qs  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rp[c]  = bp0[c] * RECIP_255;
      chk[c] = {qe1[c], 8'd0} - 25'(qe1[c]);
      qf[c]  = (chk[c] > 25'(bp1[c])) ? qe1[c] - 1'b1 : qe1[c];
      qs[c]  = qf[c][16] ? 16'hFFFF : qf[c][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        bp0[c] <= cfg.brightness * tex_rd[(2 - c) * 8 +: 8];
        bp1[c] <= bp0[c];
        qe1[c] <= rp[c][39:23];
      end
      result.ambient_red   <= qs[0];
      result.ambient_green <= qs[1];
      result.ambient_blue  <= qs[2];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sphere_texture_lookup_top.sv -----
// ----------------------------------------------------------------------------
// sphere_texture_lookup_top
// Spherical texture lookup with a loadable RGB texel store.
// ----------------------------------------------------------------------------
// Input words arrive on item with push/full; a word is taken when push is
// high and full is low. A load word writes one texel and gives no result.
// A lookup word gives one result word, shown on result while empty is low
// and taken when pop is high.
// An accepted lookup passes five front stages, the queue, 31 azimuth
// CORDIC stages, 31 polar CORDIC stages and seven stages for addressing,
// memory read and color scaling.
// Throughput is one word per cycle while the receiver does not stall; every
// CORDIC step has its own stage and the texture memory takes one access per cycle.
// Results and loads leave in order, so a lookup always sees earlier loads.
// If the receiver stalls, the back pipeline holds; the four-word queue then
// fills and full rises once the last front stage also holds a word.
// Reset clears all valid flags and sets the registers to their defaults;
// the texture memory has no reset and must be loaded before it is read.
// Registers are written over the APB-style port at byte address 4*index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sphere_texture_lookup_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  stl_pkg::in_item_t  item,
  input  logic               pop,
  output logic               empty,
  output stl_pkg::out_item_t result
);
  import stl_pkg::*;

  logic [15:0]       brightness;
  logic [15:0]       fwd_x, fwd_y, fwd_z;
  logic [SIDE_W-1:0] image_columns, image_rows;
  logic [2:0]        reg_idx;
  cfg_t              cfg;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  assign cfg.brightness = brightness;
  assign cfg.fwd_x      = fwd_x;
  assign cfg.fwd_z      = fwd_z;
  assign cfg.cols       = image_columns;
  assign cfg.rows       = image_rows;

  // Register writes land in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness    <= 16'd256;
      fwd_x         <= 16'd0;
      fwd_y         <= 16'd0;
      fwd_z         <= 16'd16384;
      image_columns <= SIDE_W'(256);
      image_rows    <= SIDE_W'(256);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_BRIGHTNESS: brightness    <= pwdata[15:0];
        REG_FORWARD_X:  fwd_x         <= pwdata[15:0];
        REG_FORWARD_Y:  fwd_y         <= pwdata[15:0];
        REG_FORWARD_Z:  fwd_z         <= pwdata[15:0];
        REG_COLUMNS:    image_columns <= pwdata[SIDE_W-1:0];
        REG_ROWS:       image_rows    <= pwdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BRIGHTNESS: prdata = {16'd0, brightness};
      REG_FORWARD_X:  prdata = {16'd0, fwd_x};
      REG_FORWARD_Y:  prdata = {16'd0, fwd_y};
      REG_FORWARD_Z:  prdata = {16'd0, fwd_z};
      REG_COLUMNS:    prdata = 32'(image_columns);
      REG_ROWS:       prdata = 32'(image_rows);
      default:        prdata = '0;
    endcase
  end

  // The front part normalizes and classifies; the back part does the math.
  logic    q_push, q_pop;
  qword_t  q_wdata, q_rdata;
  q_stat_t q_stat;

  stl_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_full (q_stat.full),
    .q_push (q_push),
    .q_word (q_wdata)
  );

  stl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  stl_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_word  (q_rdata),
    .q_empty (q_stat.empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // The input only stalls when the queue itself is full.
  `ASSERT_IMP(a_full_from_queue, clk, rst, full, q_stat.full)
  // The back part never draws from an empty queue.
  `ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, !q_stat.empty)
  // A word pushed without a matching pop is still there next cycle.
  `ASSERT_NXT(a_push_holds, clk, rst, q_push && !q_pop, !q_stat.empty)

endmodule
`default_nettype wire

// ----- tb/sphere_texture_lookup_top_tb.sv -----
// ----------------------------------------------------------------------------
// sphere_texture_lookup_top_tb
// Self-checking bench: texel loads and sphere lookups over several register
// settings, checked word by word against a built-in fixed-point predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sphere_texture_lookup_top_tb;
  import stl_pkg::*;

  // Directed row: an input word and, where it is obvious, the typed answer.
  typedef struct {
    in_item_t  w;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  in_item_t    item = '0;
  logic        pop = 1'b0;
  logic        empty;
  out_item_t   result;

  // Shadow copy of the registers and of the texel memory.
  logic [15:0]        cur_bright = 16'd256;
  logic signed [15:0] cur_fx = 16'sd0;
  logic signed [15:0] cur_fz = 16'sd16384;
  logic [8:0]         cur_cols = 9'd256;
  logic [8:0]         cur_rows = 9'd256;
  logic [23:0]        texels [TEX_DEPTH];
  bit                 loaded [TEX_DEPTH];

  out_item_t   pending_colors[$];
  stim_row_t   directed[$];
  int unsigned cyc = 0;
  bit          failed = 1'b0;
  bit          quiet;

  sphere_texture_lookup_top i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .item(item), .pop(pop), .empty(empty),
    .result(result)
  );

  always #2 clk = ~clk;

  // A long window in the middle of the run has no idling on either side.
  always @(posedge clk) cyc <= cyc + 1;
  assign quiet = (cyc >= 1200) && (cyc < 2400);

  function automatic int unsigned used_side(logic [8:0] r);
    if (r == 0) return 1;
    if (r > MAX_SIDE) return MAX_SIDE;
    return r;
  endfunction

  // Double every component until the largest magnitude reaches 2^40.
  function automatic void stretch(inout longint a, inout longint b, inout longint c);
    longint top;
    top = (a < 0) ? -a : a;
    if (((b < 0) ? -b : b) > top) top = (b < 0) ? -b : b;
    if (((c < 0) ? -c : c) > top) top = (c < 0) ? -c : c;
    if (top == 0) return;
    while (top < (64'sd1 <<< 40)) begin
      a = a * 2;
      b = b * 2;
      c = c * 2;
      top = top * 2;
    end
  endfunction

  // Vectoring CORDIC giving a binary angle (full turn = 2^32) and the
  // gain-scaled length.
  function automatic logic [31:0] bin_angle(longint x, longint y, output longint len);
    logic [31:0] a;
    longint sx, sy;
    a = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      a = HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y > 0) begin
        x = x + sx;
        y = y - sy;
        a = a + ARC_TABLE[i];
      end else begin
        x = x - sx;
        y = y + sy;
        a = a - ARC_TABLE[i];
      end
    end
    len = x;
    return a;
  endfunction

  // Ambient color that a lookup word should produce under the current setup.
  function automatic out_item_t ambient_of(in_item_t w);
    int unsigned rows, cols;
    longint dx, dy, dz, m, spare, p, fx, fz, zero;
    longint unsigned row, col, addr, v;
    logic [31:0] az_c, th, az_f, t;
    logic [23:0] rgb;
    out_item_t o;
    rows = used_side(cur_rows);
    cols = used_side(cur_cols);
    row = 0;
    col = 0;
    dx = longint'(w.hit_x) - longint'(w.centre_x);
    dy = longint'(w.hit_y) - longint'(w.centre_y);
    dz = longint'(w.hit_z) - longint'(w.centre_z);
    if (dx != 0 || dy != 0 || dz != 0) begin
      stretch(dx, dy, dz);
      if (dx == 0 && dz == 0) begin
        row = (dy > 0) ? 0 : rows - 1;
      end else begin
        az_c = bin_angle(dx, dz, m);
        p = (dy * longint'(GAIN_Q20)) >>> 20;
        th = bin_angle(p, m, spare);
        // Reflex polar angles fold to the top; anything past a half turn
        // sticks at the bottom.
        if (th >= REFLEX_LIMIT) th = '0;
        else if (th > HALF_TURN) th = HALF_TURN;
        row = (longint'(th) * rows) >> 31;
        if (row >= rows) row = rows - 1;
        fx = cur_fx;
        fz = cur_fz;
        zero = 0;
        if (fx == 0 && fz == 0) begin
          az_f = QUARTER_TURN;
        end else begin
          stretch(fx, zero, fz);
          az_f = bin_angle(fx, fz, spare);
        end
        t = (az_f + EIGHTH_TURN) - az_c;
        col = (t == 0) ? cols - 1 : (longint'(t) * cols) >> 32;
        if (col >= cols) col = cols - 1;
      end
    end
    addr = row * cols + col;
    rgb = (addr < TEX_DEPTH) ? texels[addr] : '0;
    v = (longint'(cur_bright) * rgb[23:16]) / 255;
    o.ambient_red = (v > 65535) ? 16'hFFFF : v[15:0];
    v = (longint'(cur_bright) * rgb[15:8]) / 255;
    o.ambient_green = (v > 65535) ? 16'hFFFF : v[15:0];
    v = (longint'(cur_bright) * rgb[7:0]) / 255;
    o.ambient_blue = (v > 65535) ? 16'hFFFF : v[15:0];
    return o;
  endfunction

  function automatic in_item_t load_word(int unsigned a, logic [23:0] rgb);
    in_item_t w;
    w = '0;
    w.operation = OP_LOAD;
    w.texel_address = a[15:0];
    {w.texel_red, w.texel_green, w.texel_blue} = rgb;
    // Coordinates are don't-care on a load; keep them busy anyway.
    w.hit_x = $urandom;
    w.centre_z = $urandom;
    return w;
  endfunction

  function automatic in_item_t lookup_word(int hx, int hy, int hz, int cx, int cy, int cz);
    in_item_t w;
    w = '0;
    w.operation = OP_LOOKUP;
    w.texel_address = 16'($urandom);
    w.texel_red = 8'($urandom);
    w.hit_x = hx;
    w.hit_y = hy;
    w.hit_z = hz;
    w.centre_x = cx;
    w.centre_y = cy;
    w.centre_z = cz;
    return w;
  endfunction

  // Offer one word; on acceptance update the shadow memory or queue the
  // expected color (the typed one when the caller gives it).
  task automatic send_word(in_item_t w, bit typed = 1'b0, out_item_t want = '0);
    if (!quiet && $urandom_range(99) < 14) begin
      push <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(99) < 14);
    end
    push <= 1'b1;
    item <= w;
    do @(posedge clk); while (full);
    if (w.operation == OP_LOAD) begin
      texels[w.texel_address] = {w.texel_red, w.texel_green, w.texel_blue};
      loaded[w.texel_address] = 1'b1;
    end else begin
      pending_colors.push_back(typed ? want : ambient_of(w));
    end
  endtask

  // Register write while the pipeline is empty: setup cycle, then access.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BRIGHTNESS: cur_bright = val[15:0];
      REG_FORWARD_X:  cur_fx = val[15:0];
      REG_FORWARD_Z:  cur_fz = val[15:0];
      REG_COLUMNS:    cur_cols = val[8:0];
      REG_ROWS:       cur_rows = val[8:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [15:0] b, logic [15:0] fx, logic [15:0] fy, logic [15:0] fz,
                       logic [8:0] c, logic [8:0] r);
    push <= 1'b0;
    wait (pending_colors.size() == 0);
    // Loads give no result, so let any trailing one drain as well.
    repeat (80) @(posedge clk);
    write_reg(REG_BRIGHTNESS, 32'(b));
    write_reg(REG_FORWARD_X, 32'(fx));
    write_reg(REG_FORWARD_Y, 32'(fy));
    write_reg(REG_FORWARD_Z, 32'(fz));
    write_reg(REG_COLUMNS, 32'(c));
    write_reg(REG_ROWS, 32'(r));
    // Every texel a lookup can reach must hold data before it is read.
    for (int unsigned a = 0; a < used_side(r) * used_side(c); a++) begin
      if (!loaded[a]) send_word(load_word(a, 24'($urandom)));
    end
  endtask

  task automatic random_words(int n);
    in_item_t w;
    int cx, cy, cz, span;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 25) begin
        // Mostly reload texels inside the area in use, sometimes anywhere.
        w = load_word(($urandom_range(3) == 0) ? $urandom_range(65535) :
                      $urandom_range(used_side(cur_rows) * used_side(cur_cols) - 1),
                      24'($urandom));
      end else begin
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        span = 1 << $urandom_range(30);
        case ($urandom_range(9))
          0, 1: w = lookup_word($urandom, $urandom, $urandom, cx, cy, cz);
          2:    w = lookup_word(cx, cy + $urandom_range(span) - span / 2, cz, cx, cy, cz);
          3:    w = lookup_word(cx, cy, cz, cx, cy, cz);
          default: w = lookup_word(cx + $urandom_range(span) - span / 2,
                                   cy + $urandom_range(span) - span / 2,
                                   cz + $urandom_range(span) - span / 2, cx, cy, cz);
        endcase
      end
      send_word(w);
    end
  endtask

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk) begin
    out_item_t exp_c;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_colors.size() == 0) begin
          $display("%0t: unexpected word %h", $time, result);
          failed = 1'b1;
        end else begin
          exp_c = pending_colors.pop_front();
          if (result.ambient_red !== exp_c.ambient_red) begin
            $display("%0t: red expected %h actual %h", $time, exp_c.ambient_red,
                     result.ambient_red);
            failed = 1'b1;
          end
          if (result.ambient_green !== exp_c.ambient_green) begin
            $display("%0t: green expected %h actual %h", $time, exp_c.ambient_green,
                     result.ambient_green);
            failed = 1'b1;
          end
          if (result.ambient_blue !== exp_c.ambient_blue) begin
            $display("%0t: blue expected %h actual %h", $time, exp_c.ambient_blue,
                     result.ambient_blue);
            failed = 1'b1;
          end
        end
      end
      pop <= quiet || ($urandom_range(99) >= 14);
    end
  end

  initial begin
    stim_row_t row;
    // Directed words, run under a 16 x 16 texture with reset forward (+z).
    row.typed = 1'b0;
    row.want = '0;
    row.w = load_word(0, 24'hFF0080);
    directed.push_back(row);
    row.w = load_word(65535, 24'hFFFFFF);
    directed.push_back(row);
    row.w = load_word(240, 24'h000000);
    directed.push_back(row);
    // Zero offset and straight up both read texel 0 at unity brightness.
    row.typed = 1'b1;
    row.want = '{16'd256, 16'd0, 16'd128};
    row.w = lookup_word(5, -7, 9, 5, -7, 9);
    directed.push_back(row);
    row.w = lookup_word(0, 32'sh7FFFFFFF, 0, 0, 32'sh80000000, 0);
    directed.push_back(row);
    row.w = lookup_word(0, 1, 0, 0, 0, 0);
    directed.push_back(row);
    // Straight down lands on the last row, column 0, loaded black.
    row.want = '0;
    row.w = lookup_word(0, 32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0);
    directed.push_back(row);
    row.typed = 1'b0;
    row.w = lookup_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                        32'sh80000000, 32'sh80000000, 32'sh80000000);
    directed.push_back(row);
    row.w = lookup_word(32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    directed.push_back(row);
    // Offsets along and around the bisector of forward and side.
    row.w = lookup_word(-1000, 0, 1000, 0, 0, 0);
    directed.push_back(row);
    row.w = lookup_word(-1000, 0, 1001, 0, 0, 0);
    directed.push_back(row);
    row.w = lookup_word(-1001, 0, 1000, 0, 0, 0);
    directed.push_back(row);
    row.w = lookup_word(1, 0, 0, 0, 0, 0);
    directed.push_back(row);
    row.w = lookup_word(0, 0, -1, 0, 0, 0);
    directed.push_back(row);
    row.w = lookup_word(1, -1, 0, 0, 0, 0);
    directed.push_back(row);
    row.w = lookup_word(-3, 1, -3, 0, 0, 0);
    directed.push_back(row);
    row.w = lookup_word(1, 1 << 20, 0, 0, 0, 0);
    directed.push_back(row);
    row.w = lookup_word(1, -(1 << 20), 0, 0, 0, 0);
    directed.push_back(row);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    setup(16'd256, 16'd0, 16'd0, 16'd16384, 9'd16, 9'd16);
    foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].want);
    random_words(200);
    // Extremes: full brightness, most negative forward, one wide row.
    setup(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 9'd256, 9'd1);
    random_words(200);
    // Zero brightness, one column, rows above the maximum.
    setup(16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 9'd1, 9'd511);
    random_words(180);
    // Zero horizontal forward and a zero width register.
    setup(16'd255, 16'h0000, 16'h1234, 16'h0000, 9'd0, 9'd7);
    random_words(180);
    for (int ph = 0; ph < 4; ph++) begin
      setup(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            9'($urandom_range(1, 20)), 9'($urandom_range(1, 20)));
      random_words(135);
    end
    push <= 1'b0;

    wait (pending_colors.size() == 0);
    repeat (100) @(posedge clk);
    if (!failed) begin
      $display("sphere_texture_lookup_top_tb OK");
    end else begin
      $display("sphere_texture_lookup_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far above the slowest correct run.
  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("sphere_texture_lookup_top_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
